>>> hw/rtl/range_checked_moving_average_defines.svh
// ----------------------------------------------------------------------------
// range checked moving average: assertion macros
// concurrent check wrappers on clock, disabled while reset is high
// ----------------------------------------------------------------------------
`ifndef RANGE_CHECKED_MOVING_AVERAGE_DEFINES_SVH
`define RANGE_CHECKED_MOVING_AVERAGE_DEFINES_SVH

`ifndef SYNTH
`define RCMA_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("assertion failed");
`define RCMA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define RCMA_ASSERT(lbl, prop)
`define RCMA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> hw/rtl/rcma_pkg.sv
// ----------------------------------------------------------------------------
// rcma_pkg
// shared widths, types and register codes of the range checked moving average
// ----------------------------------------------------------------------------
package rcma_pkg;

   localparam int DEPTH          = 16;
   localparam int SAMPLE_W       = 16;
   localparam int IDX_W          = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W          = $clog2(DEPTH + 1);
   localparam int SUM_W          = SAMPLE_W + $clog2(DEPTH);
   localparam int DIV_CNT_W      = $clog2(SUM_W + 1);
   localparam int STORED_COUNT_W = 5;
   localparam int REQ_TDATA_W    = 16;
   localparam int RSP_TDATA_W    = 40;
   localparam int CSR_ADDR_W     = 1;

   localparam logic [CSR_ADDR_W-1:0] CSR_LOWER_LIMIT = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_UPPER_LIMIT = 1'b1;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [SUM_W-1:0]    sum_type;
   typedef logic        [CNT_W-1:0]    count_type;

   typedef struct packed {
      logic      start;
      sum_type   dividend;
      count_type divisor;
   } div_req_type;

   typedef struct packed {
      logic       done;
      sample_type quotient;
   } div_rsp_type;

endpackage

>>> hw/rtl/rcma_ram.sv
// ----------------------------------------------------------------------------
// rcma_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module rcma_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                            wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                            rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/rcma_div.sv
// ----------------------------------------------------------------------------
// rcma_div
// restoring divider, one quotient bit per cycle, signed sum by fill count
// ----------------------------------------------------------------------------
module rcma_div
   import rcma_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 neg_ff, neg_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0]     quo_ff, quo_in;
   logic [CNT_W-1:0]     rem_ff, rem_in;
   count_type            dvs_ff, dvs_in;
   logic [CNT_W:0]       shifted;
   logic [CNT_W:0]       trial;
   logic                 ge;
   logic [SUM_W-1:0]     signed_quo;

   assign shifted = {rem_ff, quo_ff[SUM_W-1]};
   assign trial   = shifted - {1'b0, dvs_ff};
   assign ge      = (shifted >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         neg_in  = div_req.dividend[SUM_W-1];
         quo_in  = div_req.dividend[SUM_W-1] ? SUM_W'(-div_req.dividend)
                                             : SUM_W'(div_req.dividend);
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         cnt_in  = DIV_CNT_W'(SUM_W);
      end else if (busy_ff) begin
         rem_in = ge ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
         quo_in = {quo_ff[SUM_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign signed_quo       = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = signed_quo[SAMPLE_W-1:0];

endmodule

>>> hw/rtl/range_checked_moving_average.sv
// ----------------------------------------------------------------------------
// range_checked_moving_average
// range check of samples, ring history and truncated mean of stored entries
// ----------------------------------------------------------------------------
// One sample is taken at a time. A sample is checked against the lower and
// upper limit in its accept cycle and, if in range, written to the history
// ram at once. The sum is then built by reading the history one entry a cycle
// through the single ram read port, and divided by the fill count in a
// restoring divider that yields one quotient bit per cycle. The ST_OUT state
// then loads the output register. With an empty history the division is
// skipped. The result sits in an output register, so the next sample can be
// taken while it waits; a following result that finds the register still
// full holds the block until it is taken.
module range_checked_moving_average
   import rcma_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [15:0] sample
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [0] status, [16:1] current_value, [32:17] average, [37:33] stored_count
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [SAMPLE_W-1:0]    csr_wdata
);

`include "range_checked_moving_average_defines.svh"

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]             state_ff, state_in;
   sample_type             lower_ff, upper_ff;
   sample_type             latest_ff, latest_in;
   logic [IDX_W-1:0]       wr_idx_ff, wr_idx_in;
   count_type              fill_ff, fill_in;
   count_type              rd_idx_ff, rd_idx_in;
   logic                   rd_pend_ff, rd_pend_in;
   sum_type                acc_ff, acc_in;
   logic                   status_ff, status_in;
   sample_type             avg_ff, avg_in;
   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   sample_type             sample;
   logic                   reject;
   logic                   req_accept;
   logic                   ram_we;
   sample_type             ram_rdata;
   div_req_type            div_req;
   div_rsp_type            div_rsp;

   assign sample     = req_tdata[SAMPLE_W-1:0];
   assign reject     = (sample < lower_ff) || (sample > upper_ff);
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign ram_we     = req_accept && !reject;

   rcma_ram #(
      .WIDTH(SAMPLE_W),
      .DEPTH(DEPTH)
   ) u_history (
      .clock(clock),
      .we   (ram_we),
      .waddr(wr_idx_ff),
      .wdata(sample),
      .raddr(rd_idx_ff[IDX_W-1:0]),
      .rdata(ram_rdata)
   );

   rcma_div u_div (
      .clock  (clock),
      .reset  (reset),
      .div_req(div_req),
      .div_rsp(div_rsp)
   );

   always_comb begin
      state_in         = state_ff;
      latest_in        = latest_ff;
      wr_idx_in        = wr_idx_ff;
      fill_in          = fill_ff;
      rd_idx_in        = rd_idx_ff;
      rd_pend_in       = rd_pend_ff;
      acc_in           = acc_ff;
      status_in        = status_ff;
      avg_in           = avg_ff;
      rsp_data_in      = rsp_data_ff;
      rsp_tvalid_in    = rsp_tvalid_ff && !rsp_tready;
      div_req.start    = 1'b0;
      div_req.dividend = acc_ff;
      div_req.divisor  = fill_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               status_in  = reject;
               rd_idx_in  = '0;
               rd_pend_in = 1'b0;
               acc_in     = '0;
               state_in   = ST_READ;
               if (!reject) begin
                  latest_in = sample;
                  wr_idx_in = (wr_idx_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_idx_ff + 1'b1;
                  if (fill_ff < CNT_W'(DEPTH)) begin
                     fill_in = fill_ff + 1'b1;
                  end
               end
            end
         end
         ST_READ: begin
            if (rd_pend_ff) begin
               acc_in = acc_ff + sum_type'(ram_rdata);
            end
            if (rd_idx_ff != fill_ff) begin
               rd_pend_in = 1'b1;
               rd_idx_in  = rd_idx_ff + 1'b1;
            end else begin
               rd_pend_in = 1'b0;
               if (!rd_pend_ff) begin
                  if (fill_ff == '0) begin
                     avg_in   = '0;
                     state_in = ST_OUT;
                  end else begin
                     div_req.start = 1'b1;
                     state_in      = ST_DIV;
                  end
               end
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               avg_in   = div_rsp.quotient;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_data_in   = {2'b00, STORED_COUNT_W'(fill_ff), avg_ff, latest_ff, status_ff};
               rsp_tvalid_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         lower_ff      <= sample_type'(-32768);
         upper_ff      <= sample_type'(32767);
         latest_ff     <= '0;
         wr_idx_ff     <= '0;
         fill_ff       <= '0;
         rd_pend_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         latest_ff     <= latest_in;
         wr_idx_ff     <= wr_idx_in;
         fill_ff       <= fill_in;
         rd_pend_ff    <= rd_pend_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (csr_we) begin
            unique case (csr_addr)
               CSR_LOWER_LIMIT: lower_ff <= csr_wdata;
               CSR_UPPER_LIMIT: upper_ff <= csr_wdata;
               default:         lower_ff <= lower_ff;
            endcase
         end
      end
      rd_idx_ff   <= rd_idx_in;
      acc_ff      <= acc_in;
      status_ff   <= status_in;
      avg_ff      <= avg_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   `RCMA_ASSERT(a_fill_bounded, fill_ff <= CNT_W'(DEPTH))
   `RCMA_ASSERT_NEXT(a_reject_holds_fill, req_accept && reject, $stable(fill_ff) && $stable(latest_ff))
   `RCMA_ASSERT_NEXT(a_accept_updates_latest, req_accept && !reject, latest_ff == $past(sample))
   `RCMA_ASSERT(a_div_done_in_div, !div_rsp.done || (state_ff == ST_DIV))

endmodule

>>> tb/range_checked_moving_average_tb.sv
// ----------------------------------------------------------------------------
// range_checked_moving_average_tb
// Sends signed samples through the input stream and checks every result word
// against a cycle-free model of the limit check, ring history and truncated
// mean. Limit registers are rewritten between phases while the block is idle,
// covering full range, random, narrow, single-value, crossed and extreme
// settings. Both stream sides idle at random, and the receiver also holds off
// for one long stretch so that the block backs up its input.
// ----------------------------------------------------------------------------
module range_checked_moving_average_tb;
   import rcma_pkg::*;

   localparam int CYCLE_LIMIT  = 600000;
   localparam int PHASE_ITEMS  = 83;
   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE_CYCLES = 60;

   typedef struct packed {
      logic [STORED_COUNT_W-1:0] stored_count;
      sample_type                average;
      sample_type                current_value;
      logic                      status;
   } avg_word_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;   // [15:0] sample
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [0] status, [16:1] current_value, [32:17] average, [37:33] stored_count
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr = CSR_LOWER_LIMIT;
   logic [SAMPLE_W-1:0]    csr_wdata = '0;

   sample_type   pending_samples[$];
   avg_word_type expected_words[$];

   sample_type history[DEPTH];
   int         wr_idx;
   int         fill_cnt;
   sample_type latest;
   sample_type lower_lim;
   sample_type upper_lim;

   int  send_idle_pct = 9;
   int  recv_idle_pct = 72;
   int  hold_left = 0;
   logic hold_start = 1'b0;
   int  cycle_count = 0;
   int  error_count = 0;
   int  sent_count = 0;
   int  checked_count = 0;
   int  reject_count = 0;
   int  settings_count = 0;

   range_checked_moving_average dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic predict_average(input sample_type s);
      avg_word_type w;
      int sum;
      logic rejected;
      rejected = (s < lower_lim) || (s > upper_lim);
      if (!rejected) begin
         latest = s;
         history[wr_idx] = s;
         wr_idx = (wr_idx + 1 >= DEPTH) ? 0 : wr_idx + 1;
         if (fill_cnt < DEPTH) fill_cnt++;
      end else begin
         reject_count++;
      end
      sum = 0;
      for (int i = 0; i < fill_cnt; i++) sum += int'(history[i]);
      w.status        = rejected;
      w.current_value = latest;
      w.average       = (fill_cnt == 0) ? sample_type'(0) : sample_type'(sum / fill_cnt);
      w.stored_count  = fill_cnt[STORED_COUNT_W-1:0];
      expected_words.push_back(w);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tdata  <= pending_samples.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // accepted input words feed the predictor
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         sent_count++;
         predict_average(sample_type'(req_tdata));
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left == 0 && hold_start) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // monitor
   always @(posedge clock) begin
      avg_word_type got;
      avg_word_type exp_w;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
         if (rsp_tvalid && rsp_tready) begin
            got = avg_word_type'(rsp_tdata[$bits(avg_word_type)-1:0]);
            checked_count++;
            if (expected_words.size() == 0) begin
               $error("result word with nothing expected: %h", rsp_tdata);
               error_count++;
            end else begin
               exp_w = expected_words.pop_front();
               if (got.status !== exp_w.status) begin
                  $error("status expected %0d got %0d", exp_w.status, got.status);
                  error_count++;
               end
               if (got.current_value !== exp_w.current_value) begin
                  $error("current_value expected %0d got %0d",
                         exp_w.current_value, got.current_value);
                  error_count++;
               end
               if (got.average !== exp_w.average) begin
                  $error("average expected %0d got %0d", exp_w.average, got.average);
                  error_count++;
               end
               if (got.stored_count !== exp_w.stored_count) begin
                  $error("stored_count expected %0d got %0d",
                         exp_w.stored_count, got.stored_count);
                  error_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("range_checked_moving_average_tb NOT OK");
         $finish;
      end
   end

   task automatic wait_idle();
      @(negedge clock);
      while (pending_samples.size() > 0 || req_tvalid || expected_words.size() > 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limits(input sample_type lo, input sample_type hi);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= CSR_LOWER_LIMIT;
      csr_wdata <= lo;
      @(posedge clock);
      csr_addr  <= CSR_UPPER_LIMIT;
      csr_wdata <= hi;
      @(posedge clock);
      csr_we    <= 1'b0;
      lower_lim = lo;
      upper_lim = hi;
      settings_count++;
   endtask

   function automatic sample_type pick_sample(input sample_type lo, input sample_type hi);
      int r;
      r = $urandom_range(99);
      if (lo <= hi && r < 70)
         return sample_type'(int'(lo) + int'($urandom_range(int'(hi) - int'(lo))));
      if (r < 82) begin
         case ($urandom_range(3))
            0: return lo;
            1: return hi;
            2: return lo - sample_type'(1);
            default: return hi + sample_type'(1);
         endcase
      end
      return sample_type'($urandom);
   endfunction

   initial begin
      sample_type lo;
      sample_type hi;
      sample_type a;
      sample_type b;
      for (int i = 0; i < DEPTH; i++) history[i] = '0;
      wr_idx    = 0;
      fill_cnt  = 0;
      latest    = '0;
      lower_lim = sample_type'(-32768);
      upper_lim = sample_type'(32767);
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // rejects on an empty history, then both boundaries
      write_limits(sample_type'(-100), sample_type'(100));
      pending_samples = '{16'sd5000, -16'sd5000, 16'sd100, -16'sd100, 16'sd101, -16'sd101};
      wait_idle();

      // field extremes and saturation of the fill count
      write_limits(sample_type'(-32768), sample_type'(32767));
      pending_samples = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd1};
      repeat (12) pending_samples.push_back(sample_type'(32767));
      wait_idle();

      // crossed limits reject everything
      write_limits(sample_type'(10), sample_type'(-10));
      pending_samples = '{16'sd0, 16'sd10, -16'sd10};
      wait_idle();

      for (int p = 0; p < 10; p++) begin
         send_idle_pct = (p < 4) ? 9 : (p < 7) ? 72 : 0;
         recv_idle_pct = (p < 4) ? 72 : (p < 7) ? 9 : 0;
         a = sample_type'($urandom);
         b = sample_type'($urandom);
         if (a == b) b = a + sample_type'(1);
         case (p)
            0: begin lo = sample_type'(-32768); hi = sample_type'(32767); end
            1, 9: begin lo = (a < b) ? a : b; hi = (a < b) ? b : a; end
            2: begin
               lo = sample_type'($urandom_range(64000)) - sample_type'(32000);
               hi = lo + sample_type'(40);
            end
            3: begin lo = a; hi = a; end
            4: begin lo = (a < b) ? b : a; hi = (a < b) ? a : b; end
            5: begin lo = sample_type'(-32768); hi = sample_type'(-32768); end
            6: begin lo = sample_type'(32767); hi = sample_type'(32767); end
            7: begin lo = sample_type'(-32768); hi = sample_type'(0); end
            default: begin lo = sample_type'(0); hi = sample_type'(32767); end
         endcase
         write_limits(lo, hi);
         for (int i = 0; i < PHASE_ITEMS; i++) pending_samples.push_back(pick_sample(lo, hi));
         if (p == 1) begin
            @(posedge clock);
            hold_start <= 1'b1;
            @(posedge clock);
            hold_start <= 1'b0;
         end
         wait_idle();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_words.size() > 0) begin
         $error("%0d result words never arrived", expected_words.size());
         error_count++;
      end
      $display("%0d samples sent, %0d result words checked, %0d out of range",
               sent_count, checked_count, reject_count);
      $display("%0d limit settings, %0d mismatches", settings_count, error_count);
      if (error_count == 0) begin
         $display("range_checked_moving_average_tb OK");
      end else begin
         $display("range_checked_moving_average_tb NOT OK");
      end
      $finish;
   end

endmodule

>>> range_checked_moving_average.f
+incdir+hw/rtl
hw/rtl/rcma_pkg.sv
hw/rtl/rcma_ram.sv
hw/rtl/rcma_div.sv
hw/rtl/range_checked_moving_average.sv
tb/range_checked_moving_average_tb.sv
